// ===== sv/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

   // SLIP framing codes
   localparam logic [7:0] CODE_FEND  = 8'hC0;
   localparam logic [7:0] CODE_FESC  = 8'hDB;
   localparam logic [7:0] CODE_TFEND = 8'hDC;
   localparam logic [7:0] CODE_TFESC = 8'hDD;

   localparam int MAX_FRAME   = 1024;
   localparam int COUNT_WIDTH = 11;
   localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
   localparam int COUNT_LIMIT_INT = (MAX_FRAME > COUNT_MAX) ? COUNT_MAX : MAX_FRAME;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_WIDTH'(COUNT_LIMIT_INT);

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_START    = 3'd1,
      EV_DONE     = 3'd2,
      EV_OVERFLOW = 3'd3,
      EV_BAD_ESC  = 3'd4
   } event_type;

   typedef enum logic {
      KIND_BYTE  = 1'b0,
      KIND_RESET = 1'b1
   } kind_type;

   typedef struct packed {
      logic                   framing;
      logic                   escape_pending;
      logic [COUNT_WIDTH-1:0] decoded_count;
   } state_type;

   typedef struct packed {
      logic                   byte_valid;
      logic [7:0]             payload_byte;
      event_type              event_res;
      logic [COUNT_WIDTH-1:0] frame_length;
      logic                   frame_ready;
   } result_type;

endpackage

// ===== sv/sfd_step.sv =====
`timescale 1ns / 1ps

// Decode one item against the current decoder state.
module sfd_step (
   input  sfd_pkg::state_type  cur_state,
   input  logic                kind,
   input  logic [7:0]          rx_byte,
   output sfd_pkg::state_type  next_state,
   output sfd_pkg::result_type result
);

   logic                emit;
   logic [7:0]          val;
   sfd_pkg::event_type  ev;
   sfd_pkg::state_type  nxt;
   logic                at_limit;

   assign at_limit = (cur_state.decoded_count >= sfd_pkg::COUNT_LIMIT);

   always_comb begin
      nxt  = cur_state;
      emit = 1'b0;
      val  = 8'h00;
      ev   = sfd_pkg::EV_NONE;

      if (kind == sfd_pkg::KIND_RESET) begin
         nxt = '0;
      end else if (rx_byte == sfd_pkg::CODE_FEND) begin
         if (cur_state.framing && (cur_state.decoded_count != '0)) begin
            nxt.framing = 1'b0;
            ev          = sfd_pkg::EV_DONE;
         end else begin
            nxt.decoded_count = '0;
            nxt.framing       = 1'b1;
            ev                = sfd_pkg::EV_START;
         end
         nxt.escape_pending = 1'b0;
      end else if (cur_state.framing) begin
         if (cur_state.escape_pending) begin
            nxt.escape_pending = 1'b0;
            case (rx_byte)
               sfd_pkg::CODE_TFEND: begin
                  emit = 1'b1;
                  val  = sfd_pkg::CODE_FEND;
               end
               sfd_pkg::CODE_TFESC: begin
                  emit = 1'b1;
                  val  = sfd_pkg::CODE_FESC;
               end
               default: begin
                  ev = at_limit ? sfd_pkg::EV_OVERFLOW : sfd_pkg::EV_BAD_ESC;
               end
            endcase
         end else if (rx_byte == sfd_pkg::CODE_FESC) begin
            nxt.escape_pending = 1'b1;
         end else begin
            emit = 1'b1;
            val  = rx_byte;
         end

         // drop the byte once the frame is full
         if (emit && at_limit) begin
            emit = 1'b0;
            ev   = sfd_pkg::EV_OVERFLOW;
         end

         if ((ev == sfd_pkg::EV_OVERFLOW) || (ev == sfd_pkg::EV_BAD_ESC)) begin
            nxt.framing       = 1'b0;
            nxt.decoded_count = '0;
         end else if (emit) begin
            nxt.decoded_count = cur_state.decoded_count + 1'b1;
         end
      end
   end

   assign next_state          = nxt;
   assign result.byte_valid   = emit;
   assign result.payload_byte = emit ? val : 8'h00;
   assign result.event_res    = ev;
   assign result.frame_length = nxt.decoded_count;
   assign result.frame_ready  = !nxt.framing && (nxt.decoded_count != '0);

endmodule

// ===== sv/sfd_rsp_queue.sv =====
`timescale 1ns / 1ps

// Two-entry result buffer: output register plus skid entry.
module sfd_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sfd_pkg::result_type push_data,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_stall,
   output sfd_pkg::result_type pop_data
);

   sfd_pkg::result_type head_ff, head_in;
   sfd_pkg::result_type tail_ff, tail_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;

   assign pop       = (count_ff != 2'd0) && !pop_stall;
   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push_valid) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push_valid && pop) begin
               head_in = push_data;
            end else if (push_valid) begin
               tail_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push_valid)
      else $error("push into full result queue");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_stall) |=> (pop_valid && $stable(pop_data)))
      else $error("stalled result item changed");

endmodule

// ===== sv/slip_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                | Payload
// req_*    | in        | req_valid / req_stall    | req_kind, req_rx_byte
// rsp_*    | out       | rsp_valid / rsp_stall    | rsp_byte_valid, rsp_payload_byte,
//          |           |                          | rsp_event_res, rsp_frame_length,
//          |           |                          | rsp_frame_ready
//
// One item is accepted per cycle unless req_stall is high; its result is registered.
// The decode is a single pass of compares and an 11-bit increment between the
// decoder state registers and the result buffer.
// Synchronous reset clears the decoder state and empties the result buffer.
// The result buffer holds two items, so input keeps flowing after rsp_stall rises
// until the buffer fills; req_stall is a registered full flag from that buffer.
module slip_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_event_res,
   output logic [10:0] rsp_frame_length,
   output logic        rsp_frame_ready
);

   sfd_pkg::state_type  state_ff, state_in;
   sfd_pkg::state_type  step_state;
   sfd_pkg::result_type step_result;
   sfd_pkg::result_type head_result;
   logic                req_accept;
   logic                queue_full;

   // take an item whenever the result buffer has room
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   sfd_step u_step (
      .cur_state  (state_ff),
      .kind       (req_kind),
      .rx_byte    (req_rx_byte),
      .next_state (step_state),
      .result     (step_result)
   );

   // advance the decoder state only on an accepted item
   assign state_in = req_accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   sfd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_accept),
      .push_data  (step_result),
      .full       (queue_full),
      .pop_valid  (rsp_valid),
      .pop_stall  (rsp_stall),
      .pop_data   (head_result)
   );

   assign rsp_byte_valid   = head_result.byte_valid;
   assign rsp_payload_byte = head_result.payload_byte;
   assign rsp_event_res    = head_result.event_res;
   assign rsp_frame_length = head_result.frame_length;
   assign rsp_frame_ready  = head_result.frame_ready;

   // the count never runs past the frame limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.decoded_count <= sfd_pkg::COUNT_LIMIT)
      else $error("decoded count above frame limit");

   // a reset command returns the decoder to idle
   a_cmd_reset: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == sfd_pkg::KIND_RESET)) |=>
      (state_ff == '0))
      else $error("reset command did not clear decoder state");

   // an emitted byte always counts toward the frame
   a_emit_counts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && step_result.byte_valid) |=>
      (state_ff.decoded_count == $past(state_ff.decoded_count) + 11'd1))
      else $error("decoded byte not counted");

   // an escape can only be pending inside a frame
   a_escape_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff.escape_pending |-> state_ff.framing)
      else $error("escape pending outside a frame");

endmodule

// ===== tb/slip_frame_checker.sv =====
`timescale 1ns / 1ps

module slip_frame_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_byte_valid,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [2:0]  rsp_event_res,
   input  logic [10:0] rsp_frame_length,
   input  logic        rsp_frame_ready,

   output int          mismatches,
   output int          pending_results
);

   localparam int PRINT_CAP = 40;

   // Decoder state as the predictor tracks it
   logic                            framing_q;
   logic                            esc_q;
   logic [sfd_pkg::COUNT_WIDTH-1:0] count_q;

   sfd_pkg::result_type decoded_q[$];

   int fail_count = 0;
   int pending_q  = 0;

   assign mismatches      = fail_count;
   assign pending_results = pending_q;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("%0t ns: %s", $time, msg);
   endtask

   // Advance the decoder by one item and return the result it shows.
   function automatic sfd_pkg::result_type decode_item(input sfd_pkg::kind_type kind,
                                                       input logic [7:0] rx);
      sfd_pkg::result_type r;
      logic                emit;
      logic [7:0]          val;
      r = '0;
      r.event_res = sfd_pkg::EV_NONE;
      emit = 1'b0;
      val = '0;
      if (kind == sfd_pkg::KIND_RESET) begin
         framing_q = 1'b0;
         esc_q = 1'b0;
         count_q = '0;
      end else if (rx == sfd_pkg::CODE_FEND) begin
         if (framing_q && count_q != '0) begin
            framing_q = 1'b0;
            r.event_res = sfd_pkg::EV_DONE;
         end else begin
            count_q = '0;
            framing_q = 1'b1;
            r.event_res = sfd_pkg::EV_START;
         end
         esc_q = 1'b0;
      end else if (framing_q) begin
         if (esc_q) begin
            esc_q = 1'b0;
            if (rx == sfd_pkg::CODE_TFEND) begin
               emit = 1'b1;
               val = sfd_pkg::CODE_FEND;
            end else if (rx == sfd_pkg::CODE_TFESC) begin
               emit = 1'b1;
               val = sfd_pkg::CODE_FESC;
            end else if (count_q >= sfd_pkg::COUNT_LIMIT) begin
               r.event_res = sfd_pkg::EV_OVERFLOW;
            end else begin
               r.event_res = sfd_pkg::EV_BAD_ESC;
            end
         end else if (rx == sfd_pkg::CODE_FESC) begin
            esc_q = 1'b1;
         end else begin
            emit = 1'b1;
            val = rx;
         end
         // a full frame refuses any further decoded byte
         if (emit && count_q >= sfd_pkg::COUNT_LIMIT) begin
            emit = 1'b0;
            r.event_res = sfd_pkg::EV_OVERFLOW;
         end
         if (r.event_res == sfd_pkg::EV_OVERFLOW || r.event_res == sfd_pkg::EV_BAD_ESC) begin
            framing_q = 1'b0;
            count_q = '0;
         end else if (emit) begin
            r.byte_valid = 1'b1;
            r.payload_byte = val;
            count_q = count_q + 1'b1;
         end
      end
      r.frame_length = count_q;
      r.frame_ready = !framing_q && count_q != '0;
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      sfd_pkg::result_type got;
      sfd_pkg::result_type want;
      if (reset) begin
         decoded_q.delete();
         framing_q = 1'b0;
         esc_q = 1'b0;
         count_q = '0;
      end else begin
         // results are registered before they leave, so compare first
         if (rsp_valid && !rsp_stall) begin
            got.byte_valid   = rsp_byte_valid;
            got.payload_byte = rsp_payload_byte;
            got.event_res    = sfd_pkg::event_type'(rsp_event_res);
            got.frame_length = rsp_frame_length;
            got.frame_ready  = rsp_frame_ready;
            if (decoded_q.size() == 0) begin
               report_mismatch("result item with no item waiting for it");
            end else begin
               want = decoded_q.pop_front();
               if (got.byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("byte_valid got %0b want %0b",
                                            got.byte_valid, want.byte_valid));
               if (got.payload_byte !== want.payload_byte)
                  report_mismatch($sformatf("payload_byte got %02h want %02h",
                                            got.payload_byte, want.payload_byte));
               if (got.event_res !== want.event_res)
                  report_mismatch($sformatf("event_res got %0d want %0d",
                                            got.event_res, want.event_res));
               if (got.frame_length !== want.frame_length)
                  report_mismatch($sformatf("frame_length got %0d want %0d",
                                            got.frame_length, want.frame_length));
               if (got.frame_ready !== want.frame_ready)
                  report_mismatch($sformatf("frame_ready got %0b want %0b",
                                            got.frame_ready, want.frame_ready));
            end
         end
         if (req_valid && !req_stall)
            decoded_q.push_back(decode_item(sfd_pkg::kind_type'(req_kind), req_rx_byte));
      end
      pending_q <= decoded_q.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the SLIP frame decoder. Prediction and comparison
// live in the checker instantiated next to the block.
module tb;

   localparam int RANDOM_ITEMS = 450;
   localparam int LONG_HOLD    = 300;   // receiver hold-off that fills the block
   localparam int QUIET_LIMIT  = 4000;  // cycles with no item moving on either side
   localparam int END_TAIL     = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_event_res;
   logic [10:0] rsp_frame_length;
   logic        rsp_frame_ready;

   int          mismatches;
   int          pending_results;
   int          items_sent = 0;
   int          quiet_cycles = 0;

   // Handshake between the sender and the receiver for the long hold-off
   bit          hold_request = 1'b0;
   bit          hold_active = 1'b0;
   // When set, the sender offers items back to back
   bit          no_gaps = 1'b0;

   always #2 clock = ~clock;

   slip_frame_decoder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_event_res    (rsp_event_res),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_ready  (rsp_frame_ready)
   );

   slip_frame_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_event_res    (rsp_event_res),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_ready  (rsp_frame_ready),
      .mismatches       (mismatches),
      .pending_results  (pending_results)
   );

   // Gap before an item: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Length of one receiver stall; zero leaves a stretch with no stall.
   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // Payload bytes lean on the framing codes so escapes show up often.
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 9))
         0: return sfd_pkg::CODE_FEND;
         1: return sfd_pkg::CODE_FESC;
         2: return sfd_pkg::CODE_TFEND;
         3: return sfd_pkg::CODE_TFESC;
         default: return 8'($urandom);
      endcase
   endfunction

   // A byte that goes on the line as it is, one item per decoded byte.
   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == sfd_pkg::CODE_FEND || b == sfd_pkg::CODE_FESC);
      return b;
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return $urandom_range(1, 12);
      if (r < 9)
         return $urandom_range(13, 64);
      return 0;
   endfunction

   // Offer one item and hold it until the block takes it. Valid stays high
   // on return so a back-to-back item follows without a bubble.
   task automatic send_item(input sfd_pkg::kind_type kind, input logic [7:0] rx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_item(sfd_pkg::KIND_BYTE, rx);
   endtask

   // Send one payload byte in its line form, escaping the framing codes.
   task automatic send_encoded(input logic [7:0] data);
      if (data == sfd_pkg::CODE_FEND) begin
         send_byte(sfd_pkg::CODE_FESC);
         send_byte(sfd_pkg::CODE_TFEND);
      end else if (data == sfd_pkg::CODE_FESC) begin
         send_byte(sfd_pkg::CODE_FESC);
         send_byte(sfd_pkg::CODE_TFESC);
      end else begin
         send_byte(data);
      end
   endtask

   task automatic send_frame(input int len);
      send_byte(sfd_pkg::CODE_FEND);
      repeat (len) send_encoded(pick_payload());
      send_byte(sfd_pkg::CODE_FEND);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int n;
      bit held;
      held = 1'b0;
      forever begin
         if (hold_request && !held) begin
            held         = 1'b1;
            hold_active  = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active  = 1'b0;
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         n = pick_stall();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] code;
      bit         hold_done;
      bit         drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_item(sfd_pkg::KIND_RESET, 8'h00);
      send_byte(8'h00);                    // outside a frame: ignored
      send_byte(sfd_pkg::CODE_FEND);       // frame start
      send_byte(sfd_pkg::CODE_FEND);       // empty frame: restart
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sfd_pkg::CODE_FESC);       // escaped END
      send_byte(sfd_pkg::CODE_TFEND);
      send_byte(sfd_pkg::CODE_FESC);       // escaped ESC
      send_byte(sfd_pkg::CODE_TFESC);
      send_byte(sfd_pkg::CODE_FEND);       // complete, length four
      send_byte(8'h7E);                    // ignored, frame stays ready
      send_byte(sfd_pkg::CODE_FEND);       // new start clears the count
      send_byte(sfd_pkg::CODE_FESC);       // escape pending at END, empty frame
      send_byte(sfd_pkg::CODE_FEND);
      send_byte(8'h55);
      send_byte(sfd_pkg::CODE_FESC);       // escape pending at END, non-empty frame
      send_byte(sfd_pkg::CODE_FEND);
      send_byte(sfd_pkg::CODE_FEND);
      send_byte(8'hAA);
      send_byte(sfd_pkg::CODE_FESC);       // bad escape code aborts
      send_byte(8'h41);
      send_byte(sfd_pkg::CODE_FEND);
      send_byte(8'h12);
      send_item(sfd_pkg::KIND_RESET, 8'hFF);  // reset command in the middle of a frame

      // ---- random part: mostly clean frames, some noise and broken ones ----
      while (items_sent < RANDOM_ITEMS) begin
         if (!hold_done && items_sent >= 150) begin
            // stall the receiver for a long stretch while frames keep coming
            hold_done = 1'b1;
            req_valid <= 1'b0;
            hold_request = 1'b1;
            @(posedge clock);
            while (!hold_active) @(posedge clock);
            no_gaps = 1'b1;
            send_frame(40);
         end
         if (!drain_done && items_sent >= 300) begin
            drain_done = 1'b1;
            drain_results();
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 99)) inside
            [0:69]: send_frame(pick_len());
            [70:77]: begin
               // line noise, framing codes included
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            [78:85]: begin
               // bad escape; a code of END instead ends with the escape pending
               send_byte(sfd_pkg::CODE_FEND);
               repeat ($urandom_range(0, 6)) send_encoded(pick_payload());
               send_byte(sfd_pkg::CODE_FESC);
               do code = 8'($urandom);
               while (code == sfd_pkg::CODE_TFEND || code == sfd_pkg::CODE_TFESC);
               send_byte(code);
            end
            [86:91]: begin
               // frame cut short by a reset command
               send_byte(sfd_pkg::CODE_FEND);
               repeat ($urandom_range(0, 8)) send_encoded(pick_payload());
               send_item(sfd_pkg::KIND_RESET, 8'($urandom));
            end
            [92:95]: begin
               send_byte(sfd_pkg::CODE_FEND);
               repeat ($urandom_range(0, 4)) send_encoded(pick_payload());
               send_byte(sfd_pkg::CODE_FESC);
               send_byte(sfd_pkg::CODE_FEND);
            end
            default: begin
               repeat ($urandom_range(2, 4)) send_byte(sfd_pkg::CODE_FEND);
            end
         endcase
      end

      // ---- one full frame, then one of the ways past the length limit, or completion at it ----
      no_gaps = ($urandom_range(0, 1) == 0);
      send_byte(sfd_pkg::CODE_FEND);
      repeat (int'(sfd_pkg::COUNT_LIMIT)) send_byte(pick_plain());
      case ($urandom_range(0, 4))
         0: send_byte(8'h5A);
         1: begin
            send_byte(sfd_pkg::CODE_FESC);
            send_byte(sfd_pkg::CODE_TFEND);
         end
         2: begin
            // a bad code at the limit reports overflow, not a bad escape
            send_byte(sfd_pkg::CODE_FESC);
            send_byte(8'h31);
         end
         3: begin
            send_byte(sfd_pkg::CODE_FESC);
            send_byte(sfd_pkg::CODE_TFESC);
         end
         default: begin
            // a frame of exactly the limit completes
            send_byte(sfd_pkg::CODE_FEND);
            send_byte(8'h00);
            send_byte(sfd_pkg::CODE_FEND);
         end
      endcase
      no_gaps = 1'b0;

      drain_results();
      repeat (END_TAIL) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
